FILE: design/tlvp_pkg.sv
// Shared constants, types and the CRC-32 byte step for the TLV record parser.
// No dependencies; imported by tlvp_item_walker and tlv_eeprom_record_parser.
`default_nettype none

package tlvp_pkg;

    // Record size bound and the byte-position width that follows from it
    localparam int MAX_RECORD_BYTES = 2048;
    localparam int POS_W            = $clog2(MAX_RECORD_BYTES);

    // Header layout
    localparam int HDR_BYTES   = 11;
    localparam int SIG_BYTES   = 8;
    localparam int VER_POS     = 8;
    localparam int LEN_HI_POS  = 9;
    localparam int LEN_LO_POS  = 10;
    localparam logic [7:0]  HDR_VERSION = 8'h01;
    localparam logic [15:0] LEN_LIMIT   = 16'(MAX_RECORD_BYTES - HDR_BYTES);

    // Trailing CRC item, offsets counted from the body length
    localparam int CRC_TYPE_OFF = 5;
    localparam int CRC_LEN_OFF  = 6;
    localparam int LAST_OFF     = 10;
    localparam logic [7:0] TYPE_CRC     = 8'hFE;
    localparam logic [7:0] CRC_ITEM_LEN = 8'h04;

    // Item types of interest
    localparam logic [7:0] TYPE_MAC_RANGE = 8'h2A;
    localparam logic [7:0] TYPE_DEV_VER   = 8'h26;
    localparam logic [7:0] TYPE_RSVD_LO   = 8'h00;
    localparam logic [7:0] TYPE_RSVD_HI   = 8'hFF;

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Record-end status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_HDR  = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE = 3'd2;
    localparam logic [2:0] ST_NO_CRC   = 3'd3;
    localparam logic [2:0] ST_CRC_BAD  = 3'd4;

    // Walker results for the byte in hand
    typedef struct packed {
        logic       value_valid;
        logic [7:0] item_type;
        logic [7:0] value_index;
        logic [7:0] value_byte;
        logic       bad_type;
        logic [15:0] mac_count;
        logic [7:0] device_revision;
    } tlvp_walk_t;

    // Signature byte of "TlvInfo" plus terminating zero
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] s;
        unique case (idx)
            3'd0:    s = 8'h54;
            3'd1:    s = 8'h6C;
            3'd2:    s = 8'h76;
            3'd3:    s = 8'h49;
            3'd4:    s = 8'h6E;
            3'd5:    s = 8'h66;
            3'd6:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // One byte through the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        int k;
        r = c ^ {24'h000000, b};
        for (k = 0; k < 8; k++)
        begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/tlvp_item_walker.sv
// Type-length-value item walker: tracks item boundaries and captures MAC range
// and device version. Depends on tlvp_pkg.
`default_nettype none

module tlvp_item_walker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              body,
    input  wire logic              clear,
    input  wire logic [7:0]        data_byte,
    output tlvp_pkg::tlvp_walk_t   walk
);
    import tlvp_pkg::*;

    localparam logic [1:0] IT_TYPE  = 2'd0;
    localparam logic [1:0] IT_LEN   = 2'd1;
    localparam logic [1:0] IT_VALUE = 2'd2;

    logic [1:0]  item_phase_reg, item_phase_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  index_reg, index_next;
    logic        bad_reg, bad_next;
    logic [15:0] mac_reg, mac_next;
    logic [7:0]  dev_reg, dev_next;

    // Next item state for the byte in hand
    always_comb
    begin
        item_phase_next = item_phase_reg;
        type_next       = type_reg;
        left_next       = left_reg;
        index_next      = index_reg;
        bad_next        = bad_reg;
        mac_next        = mac_reg;
        dev_next        = dev_reg;
        walk            = '0;
        if (body && !bad_reg)
        begin
            unique case (item_phase_reg)
                IT_TYPE:
                begin
                    type_next = data_byte;
                    if (data_byte == TYPE_RSVD_LO || data_byte == TYPE_RSVD_HI)
                        bad_next = 1'b1;
                    else
                        item_phase_next = IT_LEN;
                end
                IT_LEN:
                begin
                    left_next  = data_byte;
                    index_next = 8'h00;
                    if (type_reg == TYPE_MAC_RANGE)
                        mac_next = 16'h0000;
                    if (type_reg == TYPE_DEV_VER)
                        dev_next = 8'h00;
                    item_phase_next = (data_byte == 8'h00) ? IT_TYPE : IT_VALUE;
                end
                IT_VALUE:
                begin
                    walk.value_valid = 1'b1;
                    walk.item_type   = type_reg;
                    walk.value_index = index_reg;
                    walk.value_byte  = data_byte;
                    if (type_reg == TYPE_MAC_RANGE)
                    begin
                        if (index_reg == 8'h00)
                            mac_next = {data_byte, 8'h00};
                        else if (index_reg == 8'h01)
                            mac_next = {mac_reg[15:8], data_byte};
                    end
                    if (type_reg == TYPE_DEV_VER && index_reg == 8'h00)
                        dev_next = data_byte;
                    index_next = index_reg + 8'h01;
                    left_next  = left_reg - 8'h01;
                    if (left_next == 8'h00)
                        item_phase_next = IT_TYPE;
                end
                default:
                begin
                    item_phase_next = IT_TYPE;
                end
            endcase
        end
        walk.bad_type        = bad_next;
        walk.mac_count       = mac_next;
        walk.device_revision = dev_next;
    end

    // Item state; back to reset at every record end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_phase_reg <= IT_TYPE;
            type_reg       <= 8'h00;
            left_reg       <= 8'h00;
            index_reg      <= 8'h00;
            bad_reg        <= 1'b0;
            mac_reg        <= 16'h0000;
            dev_reg        <= 8'h00;
        end
        else if (advance)
        begin
            if (clear)
            begin
                item_phase_reg <= IT_TYPE;
                type_reg       <= 8'h00;
                left_reg       <= 8'h00;
                index_reg      <= 8'h00;
                bad_reg        <= 1'b0;
                mac_reg        <= 16'h0000;
                dev_reg        <= 8'h00;
            end
            else
            begin
                item_phase_reg <= item_phase_next;
                type_reg       <= type_next;
                left_reg       <= left_next;
                index_reg      <= index_next;
                bad_reg        <= bad_next;
                mac_reg        <= mac_next;
                dev_reg        <= dev_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/tlv_eeprom_record_parser.sv
// Top level of the TLV record parser: input register, header and CRC logic,
// result register. Depends on tlvp_pkg and tlvp_item_walker.
`default_nettype none

// Channel   Direction  Handshake                    Payload
// byte      in         byte_valid / byte_stall      data_byte
// result    out        result_valid / result_stall  value_valid, item_type, value_index,
//                                                   value_byte, record_end, status,
//                                                   mac_count, device_revision
//
// One beat in gives one beat out; a new byte is taken every cycle unless result_stall holds a full result register.
// Each byte passes the input register, then the per-byte header, CRC-32 and
// item logic feeding the result register.
// Reset clears all record state; the first byte after reset starts a header.
// A stalled result register holds the input register, and byte_stall rises
// only when both are full.

module tlv_eeprom_record_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             value_valid,
    output logic [7:0]       item_type,
    output logic [7:0]       value_index,
    output logic [7:0]       value_byte,
    output logic             record_end,
    output logic [2:0]       status,
    output logic [15:0]      mac_count,
    output logic [7:0]       device_revision
);
    import tlvp_pkg::*;

    localparam logic PH_HEADER = 1'b0;
    localparam logic PH_BODY   = 1'b1;

    // Handshake and pipeline registers
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        result_valid_reg;
    logic        advance;
    logic        take;

    // Record state
    logic              phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              hdr_ok_reg, hdr_ok_next;
    logic [15:0]       len_reg, len_next;
    logic [31:0]       crc_reg, crc_next;
    logic [31:0]       stored_reg, stored_next;
    logic              crc_ok_reg, crc_ok_next;

    // Per-byte results
    logic              rec_end;
    logic [2:0]        status_c;
    logic [16:0]       pos_ext;
    logic [16:0]       len_ext;
    logic [31:0]       crc_upd;
    tlvp_walk_t        walk;

    // Output register
    logic              value_valid_reg;
    logic [7:0]        item_type_reg;
    logic [7:0]        value_index_reg;
    logic [7:0]        value_byte_reg;
    logic              record_end_reg;
    logic [2:0]        status_reg;
    logic [15:0]       mac_count_reg;
    logic [7:0]        device_revision_reg;

    // Flow control
    assign advance    = !result_valid_reg || !result_stall;
    assign take       = in_valid_reg && advance;
    assign byte_stall = in_valid_reg && !advance;

    assign pos_ext = 17'(pos_reg);
    assign len_ext = {1'b0, len_reg};
    assign crc_upd = crc_byte(crc_reg, in_byte_reg);

    tlvp_item_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (take),
        .body      (phase_reg == PH_BODY),
        .clear     (rec_end),
        .data_byte (in_byte_reg),
        .walk      (walk)
    );

    // Header check, CRC and record-end logic
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        hdr_ok_next = hdr_ok_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        stored_next = stored_reg;
        crc_ok_next = crc_ok_reg;
        rec_end     = 1'b0;
        status_c    = ST_OK;
        if (phase_reg == PH_HEADER)
        begin
            crc_next = crc_upd;
            if (pos_reg < POS_W'(SIG_BYTES))
            begin
                if (in_byte_reg != sig_byte(pos_reg[2:0]))
                    hdr_ok_next = 1'b0;
            end
            else if (pos_reg == POS_W'(VER_POS))
            begin
                if (in_byte_reg != HDR_VERSION)
                    hdr_ok_next = 1'b0;
            end
            else if (pos_reg == POS_W'(LEN_HI_POS))
                len_next = {in_byte_reg, 8'h00};
            else
                len_next = {len_reg[15:8], in_byte_reg};

            if (pos_reg >= POS_W'(LEN_LO_POS))
            begin
                if (len_next > LEN_LIMIT)
                    hdr_ok_next = 1'b0;
                if (!hdr_ok_next || len_next == 16'h0000)
                begin
                    rec_end  = 1'b1;
                    status_c = hdr_ok_next ? ST_NO_CRC : ST_BAD_HDR;
                end
                else
                begin
                    phase_next = PH_BODY;
                    pos_next   = POS_W'(HDR_BYTES);
                end
            end
            else
                pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            // CRC runs up to the CRC item's length byte; the last four are the stored CRC
            if (pos_ext <= len_ext + 17'(CRC_LEN_OFF))
                crc_next = crc_upd;
            else
                stored_next = {stored_reg[23:0], in_byte_reg};

            if (len_reg >= 16'(CRC_LEN_OFF))
            begin
                if (pos_ext == len_ext + 17'(CRC_TYPE_OFF))
                    crc_ok_next = (in_byte_reg == TYPE_CRC);
                else if (pos_ext == len_ext + 17'(CRC_LEN_OFF))
                    crc_ok_next = crc_ok_reg && (in_byte_reg == CRC_ITEM_LEN);
            end

            if (pos_ext >= len_ext + 17'(LAST_OFF))
            begin
                rec_end = 1'b1;
                if (!crc_ok_next)
                    status_c = ST_NO_CRC;
                else if ((crc_next ^ CRC_INIT) != stored_next)
                    status_c = ST_CRC_BAD;
                else if (walk.bad_type)
                    status_c = ST_BAD_TYPE;
                else
                    status_c = ST_OK;
            end
            else
                pos_next = pos_reg + POS_W'(1);
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!byte_stall)
            in_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            in_byte_reg <= data_byte;
    end

    // Record state; back to reset at every record end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            hdr_ok_reg <= 1'b1;
            len_reg    <= 16'h0000;
            crc_reg    <= CRC_INIT;
            stored_reg <= 32'h00000000;
            crc_ok_reg <= 1'b0;
        end
        else if (take)
        begin
            if (rec_end)
            begin
                phase_reg  <= PH_HEADER;
                pos_reg    <= '0;
                hdr_ok_reg <= 1'b1;
                len_reg    <= 16'h0000;
                crc_reg    <= CRC_INIT;
                stored_reg <= 32'h00000000;
                crc_ok_reg <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                hdr_ok_reg <= hdr_ok_next;
                len_reg    <= len_next;
                crc_reg    <= crc_next;
                stored_reg <= stored_next;
                crc_ok_reg <= crc_ok_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_valid_reg     <= walk.value_valid;
            item_type_reg       <= walk.item_type;
            value_index_reg     <= walk.value_index;
            value_byte_reg      <= walk.value_byte;
            record_end_reg      <= rec_end;
            status_reg          <= rec_end ? status_c : ST_OK;
            mac_count_reg       <= (rec_end && phase_reg == PH_BODY) ? walk.mac_count : 16'h0000;
            device_revision_reg <= (rec_end && phase_reg == PH_BODY) ? walk.device_revision
                                                                     : 8'h00;
        end
    end

    assign result_valid    = result_valid_reg;
    assign value_valid     = value_valid_reg;
    assign item_type       = item_type_reg;
    assign value_index     = value_index_reg;
    assign value_byte      = value_byte_reg;
    assign record_end      = record_end_reg;
    assign status          = status_reg;
    assign mac_count       = mac_count_reg;
    assign device_revision = device_revision_reg;

endmodule

`default_nettype wire

FILE: test/tb_tlv_eeprom_record_parser.sv
// Self-checking testbench for tlv_eeprom_record_parser: builds header and TLV
// records, predicts every per-byte result and checks it field by field.
// Depends on tlvp_pkg and the RTL under design/.

module tb_tlv_eeprom_record_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import tlvp_pkg::*;

    // "TlvInfo" plus the terminating zero, first byte in the top bits
    localparam logic [63:0] TLV_SIG = {"TlvInfo", 8'h00};

    typedef enum logic [1:0] {WALK_TYPE, WALK_LEN, WALK_VALUE} walk_state_t;

    typedef struct packed {
        logic        value_valid;
        logic [7:0]  item_type;
        logic [7:0]  value_index;
        logic [7:0]  value_byte;
        logic        record_end;
        logic [2:0]  status;
        logic [15:0] mac_count;
        logic [7:0]  device_revision;
    } byte_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  data_byte;
    logic        result_valid;
    logic        result_stall;
    logic        value_valid;
    logic [7:0]  item_type;
    logic [7:0]  value_index;
    logic [7:0]  value_byte;
    logic        record_end;
    logic [2:0]  status;
    logic [15:0] mac_count;
    logic [7:0]  device_revision;

    // Parser state as predicted
    logic        in_header;
    int          pos;
    logic        hdr_good;
    int          body_len;
    walk_state_t walk_state;
    logic [7:0]  cur_type;
    logic [7:0]  value_left;
    logic [7:0]  vidx;
    logic [31:0] crc_acc;
    logic [31:0] crc_seen;
    logic        crc_item_seen;
    logic        reserved_seen;
    logic [15:0] mac_reg;
    logic [7:0]  devrev_reg;

    byte_result_t byte_results_q[$];
    logic [7:0]   body_q[$];
    logic [7:0]   record_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    int error_count   = 0;

    tlv_eeprom_record_parser DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .data_byte       (data_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .value_valid     (value_valid),
        .item_type       (item_type),
        .value_index     (value_index),
        .value_byte      (value_byte),
        .record_end      (record_end),
        .status          (status),
        .mac_count       (mac_count),
        .device_revision (device_revision)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // CRC-32, reflected, one input bit at a time
    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void restart_record();
        in_header     = 1'b1;
        pos           = 0;
        hdr_good      = 1'b1;
        body_len      = 0;
        walk_state    = WALK_TYPE;
        cur_type      = '0;
        value_left    = '0;
        vidx          = '0;
        crc_acc       = CRC_INIT;
        crc_seen      = '0;
        crc_item_seen = 1'b0;
        reserved_seen = 1'b0;
        mac_reg       = '0;
        devrev_reg    = '0;
    endfunction

    // Advance the parser by one byte and give the result the block must emit
    function automatic byte_result_t parse_byte(input logic [7:0] b);
        byte_result_t res;
        res = '0;

        // Header: signature, version, big-endian length
        if (in_header)
        begin
            crc_acc = crc32_update(crc_acc, b);
            if (pos < 8)
            begin
                if (b != TLV_SIG[63 - 8 * pos -: 8])
                begin
                    hdr_good = 1'b0;
                end
            end
            else if (pos == 8)
            begin
                if (b != HDR_VERSION)
                begin
                    hdr_good = 1'b0;
                end
            end
            else if (pos == 9)
            begin
                body_len = int'(b) << 8;
            end
            else
            begin
                body_len = body_len | int'(b);
            end
            if (pos >= 10)
            begin
                if (body_len > int'(LEN_LIMIT))
                begin
                    hdr_good = 1'b0;
                end
                if (!hdr_good || body_len == 0)
                begin
                    res.record_end = 1'b1;
                    res.status     = hdr_good ? ST_NO_CRC : ST_BAD_HDR;
                    restart_record();
                end
                else
                begin
                    in_header = 1'b0;
                    pos       = HDR_BYTES;
                end
            end
            else
            begin
                pos++;
            end
            return res;
        end

        // Body: CRC over all but the trailing four bytes, which hold the stored CRC
        if (pos <= body_len + 6)
        begin
            crc_acc = crc32_update(crc_acc, b);
        end
        else
        begin
            crc_seen = {crc_seen[23:0], b};
        end

        // CRC item sits at fixed offsets from the end
        if (body_len >= 6)
        begin
            if (pos == body_len + 5)
            begin
                crc_item_seen = (b == TYPE_CRC);
            end
            else if (pos == body_len + 6)
            begin
                crc_item_seen = crc_item_seen && (b == CRC_ITEM_LEN);
            end
        end

        // Item walk; stops for good once a reserved type turns up
        if (!reserved_seen)
        begin
            case (walk_state)
                WALK_TYPE:
                begin
                    cur_type = b;
                    if (b == TYPE_RSVD_LO || b == TYPE_RSVD_HI)
                    begin
                        reserved_seen = 1'b1;
                    end
                    else
                    begin
                        walk_state = WALK_LEN;
                    end
                end
                WALK_LEN:
                begin
                    value_left = b;
                    vidx       = '0;
                    if (cur_type == TYPE_MAC_RANGE)
                    begin
                        mac_reg = '0;
                    end
                    if (cur_type == TYPE_DEV_VER)
                    begin
                        devrev_reg = '0;
                    end
                    walk_state = (b == 8'd0) ? WALK_TYPE : WALK_VALUE;
                end
                default:
                begin
                    res.value_valid = 1'b1;
                    res.item_type   = cur_type;
                    res.value_index = vidx;
                    res.value_byte  = b;
                    if (cur_type == TYPE_MAC_RANGE)
                    begin
                        if (vidx == 8'd0)
                        begin
                            mac_reg = {b, 8'h00};
                        end
                        else if (vidx == 8'd1)
                        begin
                            mac_reg[7:0] = b;
                        end
                    end
                    if (cur_type == TYPE_DEV_VER && vidx == 8'd0)
                    begin
                        devrev_reg = b;
                    end
                    vidx       = vidx + 8'd1;
                    value_left = value_left - 8'd1;
                    if (value_left == 8'd0)
                    begin
                        walk_state = WALK_TYPE;
                    end
                end
            endcase
        end

        // Record end: status by priority, captured values always reported
        if (pos >= body_len + 10)
        begin
            res.record_end = 1'b1;
            if (!crc_item_seen)
            begin
                res.status = ST_NO_CRC;
            end
            else if (~crc_acc != crc_seen)
            begin
                res.status = ST_CRC_BAD;
            end
            else if (reserved_seen)
            begin
                res.status = ST_BAD_TYPE;
            end
            else
            begin
                res.status = ST_OK;
            end
            res.mac_count       = mac_reg;
            res.device_revision = devrev_reg;
            restart_record();
        end
        else
        begin
            pos++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Record building
    // ------------------------------------------------------------------

    function automatic void push_item(input logic [7:0] t, input int n);
        body_q.push_back(t);
        body_q.push_back(n[7:0]);
        for (int i = 0; i < n; i++)
        begin
            body_q.push_back(8'($urandom));
        end
    endfunction

    function automatic logic [7:0] pick_type(input bit allow_reserved);
        case ($urandom_range(0, 19))
            0, 1, 2: return TYPE_MAC_RANGE;
            3, 4:    return TYPE_DEV_VER;
            5:       return allow_reserved ?
                            ($urandom_range(0, 1) ? TYPE_RSVD_HI : TYPE_RSVD_LO) : TYPE_CRC;
            default: return 8'($urandom_range(1, 254));
        endcase
    endfunction

    function automatic void build_random_body();
        int n_items;
        int n;
        body_q.delete();
        n_items = $urandom_range(0, 6);
        for (int k = 0; k < n_items; k++)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            push_item(pick_type($urandom_range(0, 3) == 0), n);
        end
    endfunction

    // Header + body_q, optionally closed by a CRC item holding the right (or a bent) CRC
    function automatic void frame_record(input bit add_crc, input bit bend_crc);
        logic [15:0] total;
        logic [31:0] c;
        total = 16'(body_q.size() + (add_crc ? 6 : 0));
        record_q.delete();
        for (int k = 0; k < 8; k++)
        begin
            record_q.push_back(TLV_SIG[63 - 8 * k -: 8]);
        end
        record_q.push_back(HDR_VERSION);
        record_q.push_back(total[15:8]);
        record_q.push_back(total[7:0]);
        foreach (body_q[i])
        begin
            record_q.push_back(body_q[i]);
        end
        if (add_crc)
        begin
            record_q.push_back(TYPE_CRC);
            record_q.push_back(CRC_ITEM_LEN);
            c = CRC_INIT;
            foreach (record_q[i])
            begin
                c = crc32_update(c, record_q[i]);
            end
            c = ~c;
            if (bend_crc)
            begin
                c = c ^ (32'h1 << $urandom_range(0, 31));
            end
            record_q.push_back(c[31:24]);
            record_q.push_back(c[23:16]);
            record_q.push_back(c[15:8]);
            record_q.push_back(c[7:0]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte channel
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_valid = 1'b1;
        data_byte  = b;
        do
        begin
            @(posedge clk);
        end
        while (byte_stall);
        byte_results_q.push_back(parse_byte(b));
        bytes_sent++;
    endtask

    task automatic send_record();
        foreach (record_q[i])
        begin
            send_byte(record_q[i]);
        end
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // ------------------------------------------------------------------
    // Result channel: random stall, checking against the oldest prediction
    // ------------------------------------------------------------------

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
        end
    endtask

    always @(posedge clk)
    begin : check_results
        byte_result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (byte_results_q.size() == 0)
            begin
                report_mismatch("result beat with no byte outstanding");
            end
            else
            begin
                want = byte_results_q.pop_front();
                check_field("value_valid", 16'(value_valid), 16'(want.value_valid));
                check_field("item_type", 16'(item_type), 16'(want.item_type));
                check_field("value_index", 16'(value_index), 16'(want.value_index));
                check_field("value_byte", 16'(value_byte), 16'(want.value_byte));
                check_field("record_end", 16'(record_end), 16'(want.record_end));
                check_field("status", 16'(status), 16'(want.status));
                check_field("mac_count", mac_count, want.mac_count);
                check_field("device_revision", 16'(device_revision),
                            16'(want.device_revision));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Header failures and the empty body; each record is 11 bytes
    task automatic test_header_checks();
        body_q.delete();
        frame_record(1'b0, 1'b0);
        send_record();

        frame_record(1'b0, 1'b0);
        record_q[$urandom_range(0, 7)] ^= 8'h20;
        send_record();

        frame_record(1'b0, 1'b0);
        record_q[8] = 8'h02;
        send_record();

        // length one past the limit, then the largest length
        frame_record(1'b0, 1'b0);
        record_q[9]  = 8'(int'(LEN_LIMIT) + 1 >> 8);
        record_q[10] = 8'(int'(LEN_LIMIT) + 1);
        send_record();

        frame_record(1'b0, 1'b0);
        record_q[9]  = 8'hFF;
        record_q[10] = 8'hFF;
        send_record();
    endtask

    // Bodies with no room for a CRC item, and a bare CRC item good and broken
    task automatic test_short_bodies();
        for (int n = 1; n <= 5; n++)
        begin
            body_q.delete();
            for (int i = 0; i < n; i++)
            begin
                body_q.push_back(8'($urandom));
            end
            frame_record(1'b0, 1'b0);
            send_record();
        end

        body_q.delete();
        frame_record(1'b1, 1'b0);
        send_record();

        frame_record(1'b1, 1'b0);
        record_q[HDR_BYTES + 1] = 8'h05;
        send_record();

        frame_record(1'b1, 1'b0);
        record_q[HDR_BYTES] = 8'hFD;
        send_record();
    endtask

    // Item walk: captured values, short values, reserved types, overrun, long value
    task automatic test_item_decode();
        body_q = {8'h2A, 8'h02, 8'h12, 8'h34, 8'h26, 8'h01, 8'hA5,
                  8'h41, 8'h00, 8'h22, 8'h03, 8'h01, 8'h02, 8'h03};
        frame_record(1'b1, 1'b0);
        send_record();

        // last item of a type wins; missing value bytes read as zero
        body_q = {8'h2A, 8'h02, 8'hAB, 8'hCD, 8'h2A, 8'h01, 8'h77,
                  8'h26, 8'h01, 8'h5A, 8'h26, 8'h00};
        frame_record(1'b1, 1'b0);
        send_record();

        body_q = {8'h2A, 8'h02, 8'h0F, 8'hF0, TYPE_RSVD_LO, 8'h33, 8'h01, 8'h44};
        frame_record(1'b1, 1'b0);
        send_record();

        // CRC mismatch outranks the reserved type
        body_q = {8'h26, 8'h01, 8'h99, TYPE_RSVD_HI, 8'h10, 8'h02, 8'h01, 8'h02};
        frame_record(1'b1, 1'b1);
        send_record();

        // value runs over the CRC item and is cut at the record end
        body_q = {8'h30, 8'hC8, 8'h01, 8'h02, 8'h03};
        frame_record(1'b1, 1'b0);
        send_record();

        body_q.delete();
        push_item(8'h55, 255);
        frame_record(1'b1, 1'b0);
        send_record();
    endtask

    // Mostly well-formed records, some broken, some header noise
    task automatic test_random_records(input int n_bytes);
        int stop_at;
        int pick;
        int idx;
        logic [15:0] big_len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            build_random_body();
            if (pick < 65)
            begin
                frame_record(1'b1, $urandom_range(0, 9) == 0);
            end
            else if (pick < 85)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        frame_record(1'b1, 1'b0);
                        idx = $urandom_range(HDR_BYTES, record_q.size() - 1);
                        record_q[idx] ^= 8'(1 << $urandom_range(0, 7));
                    end
                    1:
                    begin
                        frame_record(1'b0, 1'b0);
                    end
                    default:
                    begin
                        push_item(8'($urandom_range(1, 253)), $urandom_range(10, 255));
                        frame_record(1'b1, 1'b0);
                    end
                endcase
            end
            else
            begin
                body_q.delete();
                frame_record(1'b0, 1'b0);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        record_q[$urandom_range(0, 8)] = 8'($urandom);
                    end
                    1:
                    begin
                        big_len      = 16'($urandom_range(int'(LEN_LIMIT) + 1, 65535));
                        record_q[9]  = big_len[15:8];
                        record_q[10] = big_len[7:0];
                    end
                    default:
                    begin
                        record_q[0] = 8'($urandom_range(0, 255)) ^ 8'h80;
                        for (int i = 1; i < HDR_BYTES; i++)
                        begin
                            record_q[i] = 8'($urandom);
                        end
                    end
                endcase
            end
            send_record();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        data_byte  = '0;
        restart_record();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(38, 87);
        test_header_checks();
        test_short_bodies();
        test_item_decode();
        test_random_records(160);

        set_idling(87, 38);
        test_random_records(160);

        set_idling(0, 0);
        test_random_records(160);

        @(negedge clk);
        byte_valid = 1'b0;
        while (byte_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
